// File: design/srfc_pkg.sv
// Package for the serial reply frame checker.
// Holds item structs, byte codes, status codes and register indexes.
// Depends on nothing.
`default_nettype none
package srfc_pkg;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDR = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CTRL_ADDR = 1'd1;

	localparam logic [7:0] BYTE_PREAMBLE = 8'hFE;
	localparam logic [7:0] BYTE_END = 8'hFD;
	localparam logic [7:0] BYTE_NAK = 8'hFA;
	localparam logic [7:0] BYTE_ACK = 8'hFB;
	localparam logic [7:0] CTRL_ADDR_RESET = 8'hE0;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_ACK      = 3'd0,
		ST_DATA     = 3'd1,
		ST_SHORT    = 3'd2,
		ST_NOREPLY  = 3'd3,
		ST_BAD      = 3'd4,
		ST_REJECTED = 3'd5
	} status_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
		logic       frame_end;
		logic [6:0] echo_length;
		logic [1:0] reply_skip;
	} in_item_t;

	typedef struct packed {
		logic       result_kind;
		logic [7:0] data_byte;
		status_t    status;
		logic [7:0] payload_length;
		logic       last;
	} out_item_t;

	// Results of one processed byte, first item in item_a.
	typedef struct packed {
		logic [1:0] count;
		out_item_t  item_a;
		out_item_t  item_b;
	} res_push_t;

endpackage
`default_nettype wire

// File: design/srfc_core.sv
// Frame tracking state and per-byte result logic.
// Depends on srfc_pkg.
`default_nettype none
module srfc_core #(
	parameter int BUFFER_BYTES = 128
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 step,
	input  srfc_pkg::in_item_t  item,
	input  wire [7:0]           device_address,
	input  wire [7:0]           controller_address,
	output srfc_pkg::res_push_t push
);
	import srfc_pkg::*;

	typedef enum logic [1:0] {
		CLASS_NONE = 2'd0,
		CLASS_ACK  = 2'd1,
		CLASS_REJ  = 2'd2,
		CLASS_DATA = 2'd3
	} class_t;

	logic [7:0] byte_position_q, byte_position_n;
	logic [6:0] echo_count_q, echo_count_n;
	logic [1:0] skip_count_q, skip_count_n;
	logic [7:0] held_byte_q, held_byte_n;
	logic       held_valid_q, held_valid_n;
	class_t     reply_class_q, reply_class_n;
	logic       header_error_q, header_error_n;
	logic [7:0] payload_count_q, payload_count_n;

	logic [7:0] p_e, held_byte_e, pcount_e, pcount_mid, d, n;
	logic       held_valid_e, herr_e, kept, in_reply, payload_v;
	class_t     class_e, class_new;
	logic [8:0] first, base9;
	status_t    st;
	out_item_t  pay_item, st_item;

	always_comb begin
		echo_count_n = echo_count_q;
		skip_count_n = skip_count_q;
		p_e = byte_position_q;
		held_byte_e = held_byte_q;
		held_valid_e = held_valid_q;
		class_e = reply_class_q;
		herr_e = header_error_q;
		pcount_e = payload_count_q;
		if (item.frame_start) begin
			echo_count_n = item.echo_length;
			case (item.reply_skip)
				2'd0: skip_count_n = 2'd1;
				2'd3: skip_count_n = 2'd2;
				default: skip_count_n = item.reply_skip;
			endcase
			p_e = '0;
			held_byte_e = '0;
			held_valid_e = 1'b0;
			class_e = CLASS_NONE;
			herr_e = 1'b0;
			pcount_e = '0;
		end

		base9 = {2'b00, echo_count_n};
		first = base9 + 9'd4 + {7'd0, skip_count_n};
		kept = p_e < 8'(BUFFER_BYTES);
		in_reply = {1'b0, p_e} >= base9;
		d = p_e - {1'b0, echo_count_n};

		header_error_n = herr_e;
		class_new = class_e;
		if (kept && in_reply) begin
			if (d <= 8'd1) begin
				if (item.rx_byte != BYTE_PREAMBLE) header_error_n = 1'b1;
			end else if (d == 8'd2) begin
				if (item.rx_byte != controller_address) header_error_n = 1'b1;
			end else if (d == 8'd3) begin
				if (item.rx_byte != device_address) header_error_n = 1'b1;
			end else if (d == 8'd4) begin
				if (item.rx_byte == BYTE_NAK) class_new = CLASS_REJ;
				else if (item.rx_byte == BYTE_ACK) class_new = CLASS_ACK;
				else class_new = CLASS_DATA;
			end
		end
		reply_class_n = class_new;

		payload_v = kept && held_valid_e;
		pcount_mid = pcount_e;
		if (payload_v && pcount_e != 8'hFF) pcount_mid = pcount_e + 8'd1;

		held_byte_n = held_byte_e;
		held_valid_n = held_valid_e;
		byte_position_n = p_e;
		if (kept) begin
			held_byte_n = item.rx_byte;
			held_valid_n = ({1'b0, p_e} >= first) && (class_new == CLASS_DATA)
				&& !header_error_n;
			byte_position_n = p_e + 8'd1;
		end
		payload_count_n = pcount_mid;

		n = byte_position_n;
		if ({1'b0, n} < base9) st = ST_SHORT;
		else if ({1'b0, n} == base9) st = ST_NOREPLY;
		else if (header_error_n || ({1'b0, n} < base9 + 9'd5) || held_byte_n != BYTE_END
			|| class_new == CLASS_NONE) st = ST_BAD;
		else if (class_new == CLASS_REJ) st = ST_REJECTED;
		else if (class_new == CLASS_ACK) st = ST_ACK;
		else if ({1'b0, n} < first + 9'd1) st = ST_BAD;
		else st = ST_DATA;

		pay_item.result_kind = 1'b0;
		pay_item.data_byte = held_byte_e;
		pay_item.status = ST_DATA;
		pay_item.payload_length = '0;
		pay_item.last = 1'b0;

		st_item.result_kind = 1'b1;
		st_item.data_byte = '0;
		st_item.status = st;
		st_item.payload_length = (st == ST_ACK) ? 8'd0 : pcount_mid;
		st_item.last = 1'b1;

		if (item.frame_end) begin
			byte_position_n = '0;
			held_byte_n = '0;
			held_valid_n = 1'b0;
			reply_class_n = CLASS_NONE;
			header_error_n = 1'b0;
			payload_count_n = '0;
		end

		push.count = step ? ({1'b0, payload_v} + {1'b0, item.frame_end}) : 2'd0;
		push.item_a = payload_v ? pay_item : st_item;
		push.item_b = st_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q <= '0;
			echo_count_q <= '0;
			skip_count_q <= 2'd1;
			held_byte_q <= '0;
			held_valid_q <= 1'b0;
			reply_class_q <= CLASS_NONE;
			header_error_q <= 1'b0;
			payload_count_q <= '0;
		end else if (step) begin
			byte_position_q <= byte_position_n;
			echo_count_q <= echo_count_n;
			skip_count_q <= skip_count_n;
			held_byte_q <= held_byte_n;
			held_valid_q <= held_valid_n;
			reply_class_q <= reply_class_n;
			header_error_q <= header_error_n;
			payload_count_q <= payload_count_n;
		end
	end

endmodule
`default_nettype wire

// File: design/srfc_queue.sv
// Result queue that takes up to two items per cycle and sends one per cycle while not stalled.
// Depends on srfc_pkg.
`default_nettype none
module srfc_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  srfc_pkg::res_push_t  push,
	output logic                 room,
	output logic                 valid,
	input  wire                  stall,
	output srfc_pkg::out_item_t  item
);
	import srfc_pkg::*;

	out_item_t              entry_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic                   pop;

	assign valid = count_q != '0;
	assign item = entry_q[rd_ptr_q];
	assign pop = valid && !stall;
	assign room = count_q <= QUEUE_CNT_W'(QUEUE_DEPTH - 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(push.count);
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + QUEUE_CNT_W'(push.count) - QUEUE_CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) entry_q[wr_ptr_q] <= push.item_a;
		if (push.count == 2'd2) entry_q[wr_ptr_q + 1'b1] <= push.item_b;
	end

endmodule
`default_nettype wire

// File: design/serial_reply_frame_checker.sv
// Serial reply frame checker, top level.
// A result passes through the input register and the result queue before it can be taken.
// Throughput: one byte per cycle while the result queue has room; a byte that yields a payload and a status
// result puts two items in the four-entry result queue, drained one a cycle unless out_stall is set.
// Reset clears frame state, echo length 0, skip 1, addresses 0x00 and 0xE0.
// Depends on srfc_pkg, srfc_core and srfc_queue.
`default_nettype none
module serial_reply_frame_checker #(
	parameter int BUFFER_BYTES = 128
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_stall,
	input  srfc_pkg::in_item_t                  in_item,
	output logic                                out_valid,
	input  wire                                 out_stall,
	output srfc_pkg::out_item_t                 out_item,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire [srfc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire [7:0]                           cfg_data
);
	import srfc_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	logic [7:0] device_addr_q, ctrl_addr_q;
	logic      room, advance, load;
	res_push_t push;

	assign cfg_ready = 1'b1;
	assign advance = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign load = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			device_addr_q <= '0;
			ctrl_addr_q <= CTRL_ADDR_RESET;
		end else begin
			if (load) valid_s1 <= 1'b1;
			else if (advance) valid_s1 <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DEVICE_ADDR: device_addr_q <= cfg_data;
					REG_CTRL_ADDR: ctrl_addr_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) item_s1 <= in_item;
	end

	srfc_core #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.item(item_s1),
		.device_address(device_addr_q),
		.controller_address(ctrl_addr_q),
		.push(push)
	);

	srfc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.room(room),
		.valid(out_valid),
		.stall(out_stall),
		.item(out_item)
	);

endmodule
`default_nettype wire

// File: dv/serial_reply_frame_checker_tb.sv
// Testbench for serial_reply_frame_checker: directed reply frames, then random frames
// under several address settings, each result checked against an in-bench predictor.
// Depends on srfc_pkg and the serial_reply_frame_checker RTL.
`timescale 1ns / 1ps
module serial_reply_frame_checker_tb;
	import srfc_pkg::*;

	localparam int FRAME_BUFFER = 128;
	localparam int LIMIT_CYCLES = 400000;

	typedef logic [7:0] byte_seq_t[$];
	typedef enum logic [1:0] {CLS_NONE, CLS_ACK, CLS_REJ, CLS_DATA} reply_class_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_item;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_item;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0] cfg_data;

	serial_reply_frame_checker #(.BUFFER_BYTES(FRAME_BUFFER)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [7:0] dev_addr;
	logic [7:0] ctrl_addr;
	int unsigned byte_pos;
	int unsigned echo_len;
	int unsigned skip_len;
	int unsigned pay_count;
	logic [7:0] held;
	bit held_ok;
	reply_class_t cls;
	bit hdr_err;

	out_item_t expected_frame_results[$];
	out_item_t want;
	int errors = 0;
	int cycle_count = 0;
	int items_kept = 0;
	bit calm = 1'b0;

	function automatic out_item_t make_result(logic kind, logic [7:0] data, status_t st,
			logic [7:0] len);
		out_item_t r;
		r.result_kind = kind;
		r.data_byte = data;
		r.status = st;
		r.payload_length = len;
		r.last = kind;
		return r;
	endfunction

	function automatic void clear_frame();
		byte_pos = 0;
		held = 8'h00;
		held_ok = 1'b0;
		cls = CLS_NONE;
		hdr_err = 1'b0;
		pay_count = 0;
	endfunction

	function automatic void reset_model();
		dev_addr = 8'h00;
		ctrl_addr = CTRL_ADDR_RESET;
		echo_len = 0;
		skip_len = 1;
		clear_frame();
	endfunction

	// Returns 1 when the byte lands inside the frame buffer.
	function automatic bit predict_frame_byte(in_item_t it);
		int unsigned p;
		int unsigned first;
		int unsigned n;
		status_t st;
		bit kept;
		if (it.frame_start) begin
			clear_frame();
			echo_len = it.echo_length;
			case (it.reply_skip)
				2'd0: skip_len = 1;
				2'd3: skip_len = 2;
				default: skip_len = it.reply_skip;
			endcase
		end
		p = byte_pos;
		first = echo_len + 4 + skip_len;
		kept = p < FRAME_BUFFER;
		if (kept) begin
			if (p >= echo_len) begin
				case (p - echo_len)
					0, 1: if (it.rx_byte != BYTE_PREAMBLE) hdr_err = 1'b1;
					2: if (it.rx_byte != ctrl_addr) hdr_err = 1'b1;
					3: if (it.rx_byte != dev_addr) hdr_err = 1'b1;
					4: cls = (it.rx_byte == BYTE_NAK) ? CLS_REJ :
						(it.rx_byte == BYTE_ACK) ? CLS_ACK : CLS_DATA;
					default: ;
				endcase
			end
			if (held_ok) begin
				expected_frame_results.push_back(make_result(1'b0, held, ST_DATA, 8'd0));
				if (pay_count < 255) pay_count++;
			end
			held = it.rx_byte;
			held_ok = (p >= first) && cls == CLS_DATA && !hdr_err;
			byte_pos = p + 1;
		end
		if (it.frame_end) begin
			n = byte_pos;
			if (n < echo_len)
				st = ST_SHORT;
			else if (n == echo_len)
				st = ST_NOREPLY;
			else if (hdr_err || n < echo_len + 5 || held != BYTE_END || cls == CLS_NONE)
				st = ST_BAD;
			else if (cls == CLS_REJ)
				st = ST_REJECTED;
			else if (cls == CLS_ACK)
				st = ST_ACK;
			else if (n < first + 1)
				st = ST_BAD;
			else
				st = ST_DATA;
			expected_frame_results.push_back(make_result(1'b1, 8'h00, st,
				(st == ST_ACK) ? 8'd0 : 8'(pay_count)));
			clear_frame();
		end
		return kept;
	endfunction

	task automatic send_byte(input in_item_t it);
		while (!calm && $urandom_range(99) < 9) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (predict_frame_byte(it)) items_kept++;
	endtask

	task automatic send_bytes(input byte_seq_t bytes, input bit with_start, input bit with_end,
			input logic [6:0] echo, input logic [1:0] skip_code);
		in_item_t it;
		for (int i = 0; i < bytes.size(); i++) begin
			it.rx_byte = bytes[i];
			it.frame_start = with_start && i == 0;
			it.frame_end = with_end && i == bytes.size() - 1;
			it.echo_length = (i == 0) ? echo : 7'($urandom_range(0, 127));
			it.reply_skip = (i == 0) ? skip_code : 2'($urandom_range(0, 3));
			send_byte(it);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_frame_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_addresses(input logic [7:0] dev, input logic [7:0] ctrl);
		cfg_valid <= 1'b1;
		cfg_index <= REG_DEVICE_ADDR;
		cfg_data <= dev;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		dev_addr = dev;
		cfg_index <= REG_CTRL_ADDR;
		cfg_data <= ctrl;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		ctrl_addr = ctrl;
		cfg_valid <= 1'b0;
	endtask

	task automatic send_random_frame();
		byte_seq_t echo_part;
		byte_seq_t reply;
		byte_seq_t frame;
		byte_seq_t junk;
		logic [6:0] echo;
		logic [1:0] skip_code;
		logic [7:0] cmd;
		bit with_start;
		int r;
		int eff_skip;
		int n_pay;
		int k;
		r = $urandom_range(99);
		echo = (r < 80) ? 7'($urandom_range(6, 12)) :
			(r < 90) ? 7'($urandom_range(0, 5)) :
			(r < 95) ? 7'($urandom_range(13, 40)) : 7'($urandom_range(100, 127));
		skip_code = 2'($urandom_range(0, 3));
		with_start = $urandom_range(99) >= 10;
		// abandon a partial frame, then restart
		if ($urandom_range(99) < 5) begin
			repeat ($urandom_range(1, 10)) junk.push_back(8'($urandom));
			send_bytes(junk, 1'b1, 1'b0, 7'($urandom_range(0, 127)),
				2'($urandom_range(0, 3)));
			with_start = 1'b1;
		end
		if (!with_start) begin
			echo = 7'(echo_len);
			skip_code = 2'(skip_len);
		end
		eff_skip = (skip_code == 2'd0) ? 1 : (skip_code == 2'd3) ? 2 : skip_code;
		repeat (echo) echo_part.push_back(8'($urandom));
		reply = '{BYTE_PREAMBLE, BYTE_PREAMBLE, ctrl_addr, dev_addr};
		r = $urandom_range(99);
		if (r < 20) begin
			reply.push_back(BYTE_ACK);
			if ($urandom_range(9) == 0)
				repeat ($urandom_range(1, 3)) reply.push_back(8'($urandom));
			reply.push_back(BYTE_END);
		end else if (r < 35) begin
			reply.push_back(BYTE_NAK);
			reply.push_back(BYTE_END);
		end else if (r < 90) begin
			cmd = 8'($urandom);
			while (cmd == BYTE_NAK || cmd == BYTE_ACK) cmd = 8'($urandom);
			reply.push_back(cmd);
			if (eff_skip == 2) reply.push_back(8'($urandom));
			n_pay = ($urandom_range(9) == 0) ? $urandom_range(0, 120) : $urandom_range(0, 8);
			repeat (n_pay) reply.push_back(8'($urandom));
			reply.push_back(BYTE_END);
		end else begin
			reply.delete();
			repeat ($urandom_range(0, 12)) reply.push_back(8'($urandom));
		end
		frame = {echo_part, reply};
		if (frame.size() == 0) frame.push_back(8'($urandom));
		r = $urandom_range(99);
		if (r < 6) begin
			k = $urandom_range(0, frame.size() - 1);
			frame[k] = frame[k] ^ 8'($urandom_range(1, 255));
		end else if (r < 12 && frame.size() > 1) begin
			k = $urandom_range(1, frame.size() - 1);
			frame = frame[0:k-1];
		end
		send_bytes(frame, with_start, 1'b1, echo, skip_code);
	endtask

	task automatic test_reset_defaults();
		send_bytes('{BYTE_PREAMBLE, BYTE_PREAMBLE, CTRL_ADDR_RESET, 8'h00, BYTE_ACK, BYTE_END},
			1'b1, 1'b1, 7'd0, 2'd0);
	endtask

	task automatic test_one_byte_frames();
		send_bytes('{8'hFF}, 1'b1, 1'b1, 7'd6, 2'd1);
		send_bytes('{8'h00}, 1'b1, 1'b1, 7'd1, 2'd2);
		send_bytes('{BYTE_PREAMBLE}, 1'b1, 1'b1, 7'd0, 2'd3);
	endtask

	task automatic test_data_with_subcommand();
		send_bytes('{BYTE_PREAMBLE, BYTE_PREAMBLE, CTRL_ADDR_RESET, 8'h00, 8'h03, 8'h01,
			8'h00, 8'hFF, BYTE_END}, 1'b1, 1'b1, 7'd0, 2'd3);
	endtask

	task automatic test_rejected_reply();
		send_bytes('{BYTE_PREAMBLE, BYTE_PREAMBLE, CTRL_ADDR_RESET, 8'h00, BYTE_NAK, BYTE_END},
			1'b1, 1'b1, 7'd0, 2'd1);
	endtask

	task automatic test_random_frames(input logic [7:0] dev, input logic [7:0] ctrl,
			input int n_items, input bit no_idle);
		int base;
		wait_drained();
		set_addresses(dev, ctrl);
		calm = no_idle;
		base = items_kept;
		while (items_kept - base < n_items) send_random_frame();
		calm = 1'b0;
	endtask

	task automatic report_mismatch(input string field, input int unsigned exp_val,
			input int unsigned act_val);
		$display("%0t: %s mismatch, expected %0h actual %0h", $time, field, exp_val, act_val);
		errors++;
	endtask

	always @(posedge clk) begin
		out_stall <= arst_n && !calm && $urandom_range(99) < 9;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_frame_results.size() == 0) begin
				$display("%0t: unexpected item, expected none actual %h", $time, out_item);
				errors++;
			end else begin
				want = expected_frame_results.pop_front();
				if (out_item.result_kind !== want.result_kind)
					report_mismatch("result_kind", want.result_kind, out_item.result_kind);
				if (out_item.data_byte !== want.data_byte)
					report_mismatch("data_byte", want.data_byte, out_item.data_byte);
				if (out_item.status !== want.status)
					report_mismatch("status", want.status, out_item.status);
				if (out_item.payload_length !== want.payload_length)
					report_mismatch("payload_length", want.payload_length,
						out_item.payload_length);
				if (out_item.last !== want.last)
					report_mismatch("last", want.last, out_item.last);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("[serial_reply_frame_checker] ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_DEVICE_ADDR;
		cfg_data = 8'h00;
		reset_model();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_one_byte_frames();
		test_data_with_subcommand();
		test_rejected_reply();
		test_random_frames(8'hFF, 8'h00, 300, 1'b0);
		test_random_frames(8'h00, 8'hFF, 300, 1'b1);
		test_random_frames(8'($urandom), CTRL_ADDR_RESET, 500, 1'b0);
		test_random_frames(8'($urandom), 8'($urandom), 600, 1'b0);
		wait_drained();
		if (errors == 0)
			$display("[serial_reply_frame_checker] OK");
		else
			$display("[serial_reply_frame_checker] ERROR");
		$finish;
	end

endmodule
